### rtl/core/cnb_pkg.sv
// ----------------------------------------------------------------------------
// cnb_pkg: shared types and constants of the cutoff neighbor bond search
// Sizes, command and register codes, keep-out geometry in scaled Q7.16.
// ----------------------------------------------------------------------------
package cnb_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int MAX_BONDS  = 16;
  localparam int SEGMENTS   = 10;

  localparam int AW    = $clog2(MAX_POINTS);
  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam int NW    = $clog2(MAX_BONDS + 1);
  localparam int SEG_W = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;

  // fixed field widths
  localparam int COORD_W = 24;
  localparam int IDX_W   = 10;
  localparam int CUT_W   = 23;
  localparam int MAXN_W  = 5;
  localparam int REG_W   = 2;
  localparam int DW      = COORD_W + 1;

  // shared multiplier and accumulator
  localparam int MUL_W  = 27;
  localparam int PROD_W = 2 * MUL_W;
  localparam int HALF_W = 26;
  localparam int ACC_W  = 66;
  localparam int MW     = 32;

  // 1.01^2 and 1.00 scaled by 10^4
  localparam logic [13:0] K_CUT  = 14'd10201;
  localparam logic [13:0] K_DIST = 14'd10000;

  // geometry, coordinates scaled by 2*SEGMENTS
  localparam longint S_SCALE = 2 * SEGMENTS;
  localparam longint HOLE_R  = 332923;
  localparam longint WAIST_H = 1165230;

  localparam logic signed [MW-1:0] S_MUL = MW'(S_SCALE);
  localparam logic signed [MW-1:0] S_R   = MW'(S_SCALE * HOLE_R);
  localparam logic signed [MW-1:0] S_RN  = MW'(-S_SCALE * HOLE_R);
  localparam logic signed [MW-1:0] S_2R  = MW'(S_SCALE * 2 * HOLE_R);
  localparam logic signed [MW-1:0] S_3R  = MW'(S_SCALE * 3 * HOLE_R);
  localparam logic signed [MW-1:0] S_LO  = MW'(S_SCALE * 2 * HOLE_R);
  localparam logic signed [MW-1:0] S_HI  = MW'(S_SCALE * (2 * HOLE_R + WAIST_H));
  localparam logic [ACC_W-1:0]     RR2   =
    ACC_W'((S_SCALE * HOLE_R) * (S_SCALE * HOLE_R));

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [REG_W-1:0] REG_NEAR = 2'd0;
  localparam logic [REG_W-1:0] REG_FAR  = 2'd1;
  localparam logic [REG_W-1:0] REG_MAXN = 2'd2;

  localparam logic [CUT_W-1:0]  RST_NEAR = 23'd20972;
  localparam logic [CUT_W-1:0]  RST_FAR  = 23'd36324;
  localparam logic [MAXN_W-1:0] RST_MAXN = 5'd12;

  typedef enum logic [4:0] {
    S_IDLE, S_QLAT, S_PF_LOAD, S_SC_LO, S_SC_HI, S_SC_ADD, S_PN_MUL,
    S_PN_LOAD, S_NEAR_SAVE, S_J_RD, S_J_DAT, S_D_X, S_D_Y, S_D_Z, S_D_S,
    S_D_CMP, S_G_SEG, S_G_CIR, S_G_CY, S_G_CS, S_G_CC, S_ACC, S_OUT_MID,
    S_OUT_LAST
  } state_t;

  typedef enum logic [1:0] {PH_FAR, PH_NEAR, PH_D2} phase_t;

  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_ADD_SH} acc_op_t;

  // keep-out circle centers: top-left, top-right, bottom-left, bottom-right
  function automatic logic signed [MW-1:0] circ_x(input logic [1:0] c);
    logic signed [MW-1:0] v;
    case (c)
      2'd1, 2'd3: v = S_3R;
      default:    v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [MW-1:0] circ_y(input logic [1:0] c);
    logic signed [MW-1:0] v;
    case (c)
      2'd0, 2'd1: v = S_HI;
      default:    v = S_LO;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/cnb_in_if.sv
// ----------------------------------------------------------------------------
// cnb_in_if: command item channel
// Valid/ready channel carrying one command with point and query fields.
// ----------------------------------------------------------------------------
interface cnb_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           cmd;
  logic signed [cnb_pkg::COORD_W-1:0]   coord_x;
  logic signed [cnb_pkg::COORD_W-1:0]   coord_y;
  logic signed [cnb_pkg::COORD_W-1:0]   coord_z;
  logic [cnb_pkg::IDX_W-1:0]            query_index;

  modport source (output valid, cmd, coord_x, coord_y, coord_z, query_index,
                  input ready);
  modport sink   (input valid, cmd, coord_x, coord_y, coord_z, query_index,
                  output ready);
endinterface

### rtl/core/cnb_out_if.sv
// ----------------------------------------------------------------------------
// cnb_out_if: bond result channel
// Valid/ready channel carrying one bond item per handshake.
// ----------------------------------------------------------------------------
interface cnb_out_if;
  logic                      valid;
  logic                      ready;
  logic [cnb_pkg::IDX_W-1:0] source_index;
  logic [cnb_pkg::IDX_W-1:0] neighbor_index;
  logic                      layer;
  logic                      found;
  logic                      last;

  modport source (output valid, source_index, neighbor_index, layer, found, last,
                  input ready);
  modport sink   (input valid, source_index, neighbor_index, layer, found, last,
                  output ready);
endinterface

### rtl/core/cnb_cfg_if.sv
// ----------------------------------------------------------------------------
// cnb_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface cnb_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [cnb_pkg::REG_W-1:0] index;
  logic [cnb_pkg::CUT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/cnb_ram.sv
// ----------------------------------------------------------------------------
// cnb_ram: generic single-write, single-read RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cnb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/cutoff_neighbor_bond_search.sv
// ----------------------------------------------------------------------------
// cutoff_neighbor_bond_search: brute-force neighbor bond search with keep-out
// Stores points, then scans all stored points against a query particle.
// ----------------------------------------------------------------------------
// Clear and load items give no result. A query first computes the squared
// cutoffs, then scans each stored candidate (skipping the query point itself);
// a candidate inside the far cutoff has its segments checked against the
// keep-out geometry before it is kept as a bond; a final item ends the scan.
// One item at a time through the shared 27x27 multiplier; not ready meanwhile.
// rst_n (synchronous, active low) empties the store, loads default registers.
module cutoff_neighbor_bond_search (
  input  logic        clk,
  input  logic        rst_n,
  cnb_in_if.sink      in_ch,
  cnb_out_if.source   out_ch,
  cnb_cfg_if.sink     cfg_ch
);

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  cnb_pkg::state_t  state_r, state_nxt;
  cnb_pkg::phase_t  phase_r;
  cnb_pkg::acc_op_t acc_op;

  logic [cnb_pkg::CUT_W-1:0]  cfg_near_r, cfg_far_r;
  logic [cnb_pkg::MAXN_W-1:0] cfg_maxn_r;
  logic [cnb_pkg::CW-1:0]     count_r;
  logic [cnb_pkg::CW-1:0]     j_r;
  logic [cnb_pkg::NW-1:0]     n_r;
  logic [cnb_pkg::NW-1:0]     lim;
  logic [cnb_pkg::IDX_W-1:0]  q_r;

  logic signed [cnb_pkg::COORD_W-1:0] xi_r, yi_r, zi_r;
  logic signed [cnb_pkg::DW-1:0]      dx_r, dy_r, dz_r;
  logic signed [cnb_pkg::MW-1:0]      mx_r, my_r;
  logic [cnb_pkg::SEG_W-1:0]          k_r;
  logic [1:0]                         c_r;
  logic                               layer_r;

  logic                       pend_v_r;
  logic [cnb_pkg::IDX_W-1:0]  pend_nbr_r;
  logic                       pend_layer_r;

  // shared multiply / accumulate unit
  logic signed [cnb_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [cnb_pkg::PROD_W-1:0] prod_r;
  logic [cnb_pkg::ACC_W-1:0]         acc_r;
  logic [cnb_pkg::ACC_W-1:0]         prod_ext;
  logic [cnb_pkg::ACC_W-1:0]         far2_r, near2_r;

  // RAM ports
  logic                         ram_we;
  logic [cnb_pkg::AW-1:0]       ram_raddr;
  logic [cnb_pkg::COORD_W-1:0]  rd_x, rd_y, rd_z;

  // control flags
  logic in_acc, out_acc, scan_end, skip_self;
  logic rect_hit, box_hit, last_circ, seg_done;
  logic adv_j, take_bond;
  logic signed [cnb_pkg::MW-1:0] ddx, ddy;

  assign in_acc  = in_ch.valid & in_ch.ready;
  assign out_acc = out_ch.valid & out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign lim = (cfg_maxn_r > cnb_pkg::MAX_BONDS) ? cnb_pkg::NW'(cnb_pkg::MAX_BONDS)
                                                 : cnb_pkg::NW'(cfg_maxn_r);

  assign scan_end  = (j_r == count_r) || (n_r == lim);
  assign skip_self = (j_r == cnb_pkg::CW'(q_r));

  // --------------------------------------------------------------------------
  // point store: one RAM per axis, appended at count_r
  // --------------------------------------------------------------------------
  assign ram_we = in_acc && (in_ch.cmd == cnb_pkg::CMD_LOAD) &&
                  (count_r < cnb_pkg::CW'(cnb_pkg::MAX_POINTS));
  assign ram_raddr = (state_r == cnb_pkg::S_IDLE) ? cnb_pkg::AW'(in_ch.query_index)
                                                  : j_r[cnb_pkg::AW-1:0];

  cnb_ram #(.WIDTH(cnb_pkg::COORD_W), .DEPTH(cnb_pkg::MAX_POINTS)) u_ram_x (
    .clk(clk), .we(ram_we), .waddr(count_r[cnb_pkg::AW-1:0]),
    .wdata(in_ch.coord_x), .raddr(ram_raddr), .rdata(rd_x));
  cnb_ram #(.WIDTH(cnb_pkg::COORD_W), .DEPTH(cnb_pkg::MAX_POINTS)) u_ram_y (
    .clk(clk), .we(ram_we), .waddr(count_r[cnb_pkg::AW-1:0]),
    .wdata(in_ch.coord_y), .raddr(ram_raddr), .rdata(rd_y));
  cnb_ram #(.WIDTH(cnb_pkg::COORD_W), .DEPTH(cnb_pkg::MAX_POINTS)) u_ram_z (
    .clk(clk), .we(ram_we), .waddr(count_r[cnb_pkg::AW-1:0]),
    .wdata(in_ch.coord_z), .raddr(ram_raddr), .rdata(rd_z));

  // --------------------------------------------------------------------------
  // keep-out geometry for the current midpoint (scaled coordinates)
  // --------------------------------------------------------------------------
  // left rectangle starts at x = 0: a clear sign bit is the lower bound
  assign rect_hit = (my_r >= cnb_pkg::S_LO) && (my_r <= cnb_pkg::S_HI) &&
                    ((!mx_r[cnb_pkg::MW-1] && (mx_r <= cnb_pkg::S_R)) ||
                     ((mx_r >= cnb_pkg::S_2R) && (mx_r <= cnb_pkg::S_3R)));
  assign ddx = mx_r - cnb_pkg::circ_x(c_r);
  assign ddy = my_r - cnb_pkg::circ_y(c_r);
  // square only when the midpoint sits in the circle's bounding box
  assign box_hit = (ddx <= cnb_pkg::S_R) && (ddx >= cnb_pkg::S_RN) &&
                   (ddy <= cnb_pkg::S_R) && (ddy >= cnb_pkg::S_RN);
  assign last_circ = (c_r == 2'd3);
  assign seg_done  = (k_r == cnb_pkg::SEG_W'(cnb_pkg::SEGMENTS - 1));

  // --------------------------------------------------------------------------
  // next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cnb_pkg::S_IDLE: begin
        if (in_acc && in_ch.cmd == cnb_pkg::CMD_QUERY) state_nxt = cnb_pkg::S_QLAT;
      end
      cnb_pkg::S_QLAT: begin
        if ((cnb_pkg::CW'(q_r) >= count_r) || (lim == '0)) begin
          state_nxt = cnb_pkg::S_OUT_LAST;
        end else begin
          state_nxt = cnb_pkg::S_PF_LOAD;
        end
      end
      cnb_pkg::S_PF_LOAD: state_nxt = cnb_pkg::S_SC_LO;
      cnb_pkg::S_SC_LO:   state_nxt = cnb_pkg::S_SC_HI;
      cnb_pkg::S_SC_HI:   state_nxt = cnb_pkg::S_SC_ADD;
      cnb_pkg::S_SC_ADD: begin
        case (phase_r)
          cnb_pkg::PH_FAR:  state_nxt = cnb_pkg::S_PN_MUL;
          cnb_pkg::PH_NEAR: state_nxt = cnb_pkg::S_NEAR_SAVE;
          default:          state_nxt = cnb_pkg::S_D_CMP;
        endcase
      end
      cnb_pkg::S_PN_MUL:    state_nxt = cnb_pkg::S_PN_LOAD;
      cnb_pkg::S_PN_LOAD:   state_nxt = cnb_pkg::S_SC_LO;
      cnb_pkg::S_NEAR_SAVE: state_nxt = cnb_pkg::S_J_RD;
      cnb_pkg::S_J_RD: begin
        if (scan_end)        state_nxt = cnb_pkg::S_OUT_LAST;
        else if (!skip_self) state_nxt = cnb_pkg::S_J_DAT;
      end
      cnb_pkg::S_J_DAT: state_nxt = cnb_pkg::S_D_X;
      cnb_pkg::S_D_X:   state_nxt = cnb_pkg::S_D_Y;
      cnb_pkg::S_D_Y:   state_nxt = cnb_pkg::S_D_Z;
      cnb_pkg::S_D_Z:   state_nxt = cnb_pkg::S_D_S;
      cnb_pkg::S_D_S:   state_nxt = cnb_pkg::S_SC_LO;
      cnb_pkg::S_D_CMP: begin
        state_nxt = (acc_r >= far2_r) ? cnb_pkg::S_J_RD : cnb_pkg::S_G_SEG;
      end
      cnb_pkg::S_G_SEG: begin
        state_nxt = rect_hit ? cnb_pkg::S_J_RD : cnb_pkg::S_G_CIR;
      end
      cnb_pkg::S_G_CIR: begin
        if (box_hit)        state_nxt = cnb_pkg::S_G_CY;
        else if (!last_circ) state_nxt = cnb_pkg::S_G_CIR;
        else if (seg_done)  state_nxt = cnb_pkg::S_ACC;
        else                state_nxt = cnb_pkg::S_G_SEG;
      end
      cnb_pkg::S_G_CY: state_nxt = cnb_pkg::S_G_CS;
      cnb_pkg::S_G_CS: state_nxt = cnb_pkg::S_G_CC;
      cnb_pkg::S_G_CC: begin
        if (acc_r <= cnb_pkg::RR2) state_nxt = cnb_pkg::S_J_RD;
        else if (!last_circ)       state_nxt = cnb_pkg::S_G_CIR;
        else if (seg_done)         state_nxt = cnb_pkg::S_ACC;
        else                       state_nxt = cnb_pkg::S_G_SEG;
      end
      cnb_pkg::S_ACC: begin
        state_nxt = pend_v_r ? cnb_pkg::S_OUT_MID : cnb_pkg::S_J_RD;
      end
      cnb_pkg::S_OUT_MID: begin
        if (out_acc) state_nxt = cnb_pkg::S_J_RD;
      end
      cnb_pkg::S_OUT_LAST: begin
        if (out_acc) state_nxt = cnb_pkg::S_IDLE;
      end
      default: state_nxt = cnb_pkg::S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // outputs: handshakes, multiplier operands, accumulator op
  // --------------------------------------------------------------------------
  always_comb begin
    in_ch.ready  = (state_r == cnb_pkg::S_IDLE);
    out_ch.valid = (state_r == cnb_pkg::S_OUT_MID) || (state_r == cnb_pkg::S_OUT_LAST);
    mul_a  = '0;
    mul_b  = '0;
    acc_op = cnb_pkg::ACC_HOLD;
    adv_j     = 1'b0;
    take_bond = 1'b0;
    case (state_r)
      cnb_pkg::S_QLAT: begin
        mul_a = cnb_pkg::MUL_W'(cfg_far_r);
        mul_b = cnb_pkg::MUL_W'(cfg_far_r);
      end
      cnb_pkg::S_PN_MUL: begin
        mul_a = cnb_pkg::MUL_W'(cfg_near_r);
        mul_b = cnb_pkg::MUL_W'(cfg_near_r);
      end
      cnb_pkg::S_PF_LOAD, cnb_pkg::S_PN_LOAD: acc_op = cnb_pkg::ACC_LOAD;
      cnb_pkg::S_SC_LO: begin
        mul_a = cnb_pkg::MUL_W'(acc_r[cnb_pkg::HALF_W-1:0]);
        mul_b = cnb_pkg::MUL_W'((phase_r == cnb_pkg::PH_D2) ? cnb_pkg::K_DIST
                                                            : cnb_pkg::K_CUT);
      end
      cnb_pkg::S_SC_HI: begin
        mul_a  = cnb_pkg::MUL_W'(acc_r[2*cnb_pkg::HALF_W-1:cnb_pkg::HALF_W]);
        mul_b  = cnb_pkg::MUL_W'((phase_r == cnb_pkg::PH_D2) ? cnb_pkg::K_DIST
                                                             : cnb_pkg::K_CUT);
        acc_op = cnb_pkg::ACC_LOAD;
      end
      cnb_pkg::S_SC_ADD: acc_op = cnb_pkg::ACC_ADD_SH;
      cnb_pkg::S_J_RD: adv_j = !scan_end && skip_self;
      cnb_pkg::S_D_X: begin
        mul_a = cnb_pkg::MUL_W'(dx_r);
        mul_b = cnb_pkg::MUL_W'(dx_r);
      end
      cnb_pkg::S_D_Y: begin
        mul_a  = cnb_pkg::MUL_W'(dy_r);
        mul_b  = cnb_pkg::MUL_W'(dy_r);
        acc_op = cnb_pkg::ACC_LOAD;
      end
      cnb_pkg::S_D_Z: begin
        mul_a  = cnb_pkg::MUL_W'(dz_r);
        mul_b  = cnb_pkg::MUL_W'(dz_r);
        acc_op = cnb_pkg::ACC_ADD;
      end
      cnb_pkg::S_D_S:   acc_op = cnb_pkg::ACC_ADD;
      cnb_pkg::S_D_CMP: adv_j = (acc_r >= far2_r);
      cnb_pkg::S_G_SEG: adv_j = rect_hit;
      cnb_pkg::S_G_CIR: begin
        mul_a = cnb_pkg::MUL_W'(ddx);
        mul_b = cnb_pkg::MUL_W'(ddx);
      end
      cnb_pkg::S_G_CY: begin
        mul_a  = cnb_pkg::MUL_W'(ddy);
        mul_b  = cnb_pkg::MUL_W'(ddy);
        acc_op = cnb_pkg::ACC_LOAD;
      end
      cnb_pkg::S_G_CS: acc_op = cnb_pkg::ACC_ADD;
      cnb_pkg::S_G_CC: adv_j = (acc_r <= cnb_pkg::RR2);
      cnb_pkg::S_ACC: begin
        take_bond = !pend_v_r;
        adv_j     = !pend_v_r;
      end
      cnb_pkg::S_OUT_MID: begin
        take_bond = out_acc;
        adv_j     = out_acc;
      end
      default: ;
    endcase
  end

  // result fields: a held bond is flushed when the next one arrives or at the end
  assign out_ch.source_index   = q_r;
  assign out_ch.neighbor_index = pend_v_r ? pend_nbr_r : '0;
  assign out_ch.layer          = pend_v_r & pend_layer_r;
  assign out_ch.found          = (state_r == cnb_pkg::S_OUT_MID) || pend_v_r;
  assign out_ch.last           = (state_r == cnb_pkg::S_OUT_LAST);

  // --------------------------------------------------------------------------
  // control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= cnb_pkg::S_IDLE;
      count_r    <= '0;
      pend_v_r   <= 1'b0;
      n_r        <= '0;
      cfg_near_r <= cnb_pkg::RST_NEAR;
      cfg_far_r  <= cnb_pkg::RST_FAR;
      cfg_maxn_r <= cnb_pkg::RST_MAXN;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          cnb_pkg::REG_NEAR: cfg_near_r <= cfg_ch.data;
          cnb_pkg::REG_FAR:  cfg_far_r  <= cfg_ch.data;
          cnb_pkg::REG_MAXN: cfg_maxn_r <= cfg_ch.data[cnb_pkg::MAXN_W-1:0];
          default: ;
        endcase
      end
      if (in_acc && in_ch.cmd == cnb_pkg::CMD_CLEAR) count_r <= '0;
      if (ram_we) count_r <= count_r + 1'b1;
      if (in_acc && in_ch.cmd == cnb_pkg::CMD_QUERY) begin
        pend_v_r <= 1'b0;
        n_r      <= '0;
      end
      if (take_bond) begin
        pend_v_r <= 1'b1;
        n_r      <= n_r + 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // datapath registers
  // --------------------------------------------------------------------------
  assign prod_ext = cnb_pkg::ACC_W'(prod_r[cnb_pkg::PROD_W-2:0]);

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (acc_op)
      cnb_pkg::ACC_LOAD:   acc_r <= prod_ext;
      cnb_pkg::ACC_ADD:    acc_r <= acc_r + prod_ext;
      cnb_pkg::ACC_ADD_SH: acc_r <= acc_r + (prod_ext << cnb_pkg::HALF_W);
      default: ;
    endcase

    if (in_acc && in_ch.cmd == cnb_pkg::CMD_QUERY) begin
      q_r <= in_ch.query_index;
      j_r <= '0;
    end
    if (adv_j) j_r <= j_r + 1'b1;

    case (state_r)
      cnb_pkg::S_QLAT: begin
        xi_r <= rd_x;
        yi_r <= rd_y;
        zi_r <= rd_z;
      end
      cnb_pkg::S_PF_LOAD: phase_r <= cnb_pkg::PH_FAR;
      cnb_pkg::S_PN_MUL:  far2_r  <= acc_r;
      cnb_pkg::S_PN_LOAD: phase_r <= cnb_pkg::PH_NEAR;
      cnb_pkg::S_NEAR_SAVE: near2_r <= acc_r;
      cnb_pkg::S_J_DAT: begin
        dx_r <= cnb_pkg::DW'(signed'(rd_x)) - cnb_pkg::DW'(xi_r);
        dy_r <= cnb_pkg::DW'(signed'(rd_y)) - cnb_pkg::DW'(yi_r);
        dz_r <= cnb_pkg::DW'(signed'(rd_z)) - cnb_pkg::DW'(zi_r);
      end
      cnb_pkg::S_D_S: phase_r <= cnb_pkg::PH_D2;
      cnb_pkg::S_D_CMP: begin
        // first segment midpoint: S*p_i + d
        layer_r <= (acc_r >= near2_r);
        mx_r    <= cnb_pkg::MW'(xi_r) * cnb_pkg::S_MUL + cnb_pkg::MW'(dx_r);
        my_r    <= cnb_pkg::MW'(yi_r) * cnb_pkg::S_MUL + cnb_pkg::MW'(dy_r);
        k_r     <= '0;
      end
      cnb_pkg::S_G_SEG: c_r <= 2'd0;
      cnb_pkg::S_G_CIR, cnb_pkg::S_G_CC: begin
        if ((state_r == cnb_pkg::S_G_CC) || !box_hit) begin
          c_r <= c_r + 1'b1;
          if (last_circ && !seg_done) begin
            // next midpoint is 2*d further along
            k_r  <= k_r + 1'b1;
            mx_r <= mx_r + (cnb_pkg::MW'(dx_r) <<< 1);
            my_r <= my_r + (cnb_pkg::MW'(dy_r) <<< 1);
          end
        end
      end
      default: ;
    endcase

    if (take_bond) begin
      pend_nbr_r   <= j_r[cnb_pkg::IDX_W-1:0];
      pend_layer_r <= layer_r;
    end
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input taken while a result is pending");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cnb_pkg::CW'(cnb_pkg::MAX_POINTS))
    else $error("point count beyond store depth");

  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.found) |-> (out_ch.last && out_ch.neighbor_index == '0))
    else $error("empty result is not a lone final item");

  a_bond_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cnb_pkg::S_OUT_MID) |-> (n_r < lim))
    else $error("bond emitted past the limit");
`endif

endmodule

### dv/tb_cutoff_neighbor_bond_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cutoff_neighbor_bond_search: self-checking bench of the bond search
// Loads point clusters around the keep-out geometry, queries bonds under
// several cutoff and bond-limit settings, and checks every bond item against
// a built-in bond predictor. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_cutoff_neighbor_bond_search;

  localparam int  WATCHDOG_LIMIT = 400000;
  localparam int  DRAIN_CYCLES   = 40;
  localparam int  RAND_PHASES    = 8;
  localparam int  PHASE_ITEMS    = 40;
  localparam int  CLUSTER_CAP    = 40;
  localparam logic [1:0] CMD_NOP = 2'd3;   // unknown command, ignored

  // keep-out geometry in Q7.16, midpoints scaled by 2*SEGMENTS
  localparam longint GEO_S  = 2 * cnb_pkg::SEGMENTS;
  localparam longint GEO_R  = 332923;
  localparam longint GEO_LO = 2 * GEO_R;
  localparam longint GEO_HI = 2 * GEO_R + 1165230;

  typedef struct packed {
    logic [cnb_pkg::IDX_W-1:0] src;
    logic [cnb_pkg::IDX_W-1:0] nbr;
    logic                      layer;
    logic                      found;
    logic                      last;
  } bond_t;

  typedef struct {
    logic [1:0]                         cmd;
    logic signed [cnb_pkg::COORD_W-1:0] x, y, z;
    logic [cnb_pkg::IDX_W-1:0]          qi;
    bit                                 typed;   // expect a bare "no bond" item
  } stim_t;

  logic clk = 1'b0;
  logic rst_n;

  cnb_in_if  in_ch();
  cnb_out_if out_ch();
  cnb_cfg_if cfg_ch();

  cutoff_neighbor_bond_search dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: shadow point store and registers
  // ---------------------------------------------------------------------------
  logic signed [cnb_pkg::COORD_W-1:0] pt_x [cnb_pkg::MAX_POINTS];
  logic signed [cnb_pkg::COORD_W-1:0] pt_y [cnb_pkg::MAX_POINTS];
  logic signed [cnb_pkg::COORD_W-1:0] pt_z [cnb_pkg::MAX_POINTS];
  int unsigned                        pt_count;
  logic [cnb_pkg::CUT_W-1:0]          near_cut, far_cut;
  logic [cnb_pkg::MAXN_W-1:0]         bond_limit;

  bond_t expected_bonds[$];
  int    errors;
  int    n_items, n_queries, n_bonds, n_cfg;
  int    idle_cycles;
  int    stall_mode;   // receiver pattern
  bit    bursty;       // sender gaps on/off

  // append one item to the expected result queue
  task automatic expect_item(input bond_t b);
    expected_bonds = {expected_bonds, b};
  endtask

  // true when scaled point (mx,my) falls in a keep-out region
  function automatic bit in_keepout(longint mx, longint my);
    longint cx [4];
    longint cy [4];
    longint rr, dx, dy;
    bit     hit;
    cx = '{0, 3 * GEO_R, 0, 3 * GEO_R};
    cy = '{GEO_HI, GEO_HI, GEO_LO, GEO_LO};
    rr = GEO_S * GEO_R;
    hit = 1'b0;
    for (int c = 0; c < 4; c++) begin
      dx = mx - GEO_S * cx[c];
      dy = my - GEO_S * cy[c];
      if (dx <= rr && dx >= -rr && dy <= rr && dy >= -rr &&
          dx * dx + dy * dy <= rr * rr) hit = 1'b1;
    end
    // the two waist rectangles, boundaries inclusive
    if (my >= GEO_S * GEO_LO && my <= GEO_S * GEO_HI) begin
      if (mx >= 0 && mx <= GEO_S * GEO_R) hit = 1'b1;
      if (mx >= GEO_S * 2 * GEO_R && mx <= GEO_S * 3 * GEO_R) hit = 1'b1;
    end
    return hit;
  endfunction

  // a bond is clear when no segment midpoint lands in a keep-out region
  function automatic bit bond_clear(int unsigned i, int unsigned j);
    longint xi, yi, dx, dy;
    bit     ok;
    xi = pt_x[i];
    yi = pt_y[i];
    dx = longint'(pt_x[j]) - xi;
    dy = longint'(pt_y[j]) - yi;
    ok = 1'b1;
    for (longint k = 0; k < cnb_pkg::SEGMENTS; k++)
      if (in_keepout(GEO_S * xi + (2 * k + 1) * dx, GEO_S * yi + (2 * k + 1) * dy))
        ok = 1'b0;
    return ok;
  endfunction

  // update shadow state for one accepted item, queue the bonds it yields
  task automatic predict_bonds(input stim_t s);
    int unsigned lim, n;
    longint      dx, dy, dz;
    logic [63:0] d2, far2, near2;
    bond_t       b;
    case (s.cmd)
      cnb_pkg::CMD_CLEAR: pt_count = 0;
      cnb_pkg::CMD_LOAD: begin
        if (pt_count < cnb_pkg::MAX_POINTS) begin
          pt_x[pt_count] = s.x;
          pt_y[pt_count] = s.y;
          pt_z[pt_count] = s.z;
          pt_count++;
        end
      end
      cnb_pkg::CMD_QUERY: begin
        n_queries++;
        lim   = (bond_limit < cnb_pkg::MAX_BONDS) ? bond_limit : cnb_pkg::MAX_BONDS;
        far2  = 64'(far_cut) * 64'(far_cut) * 64'd10201;
        near2 = 64'(near_cut) * 64'(near_cut) * 64'd10201;
        n = 0;
        if (s.qi < pt_count) begin
          for (int unsigned j = 0; j < pt_count && n < lim; j++) begin
            if (j == s.qi) continue;
            dx = longint'(pt_x[j]) - pt_x[s.qi];
            dy = longint'(pt_y[j]) - pt_y[s.qi];
            dz = longint'(pt_z[j]) - pt_z[s.qi];
            // 64-bit wrap is part of the defined behavior
            d2 = 64'(dx * dx) + 64'(dy * dy) + 64'(dz * dz);
            d2 = d2 * 64'd10000;
            if (d2 >= far2) continue;
            if (!bond_clear(s.qi, j)) continue;
            b = '{src: s.qi, nbr: j[cnb_pkg::IDX_W-1:0], layer: (d2 >= near2),
                  found: 1'b1, last: 1'b0};
            expect_item(b);
            n++;
          end
        end
        if (n == 0) expect_item('{s.qi, '0, 1'b0, 1'b0, 1'b1});
        else expected_bonds[$].last = 1'b1;
      end
      default: ;  // unknown command, ignored
    endcase
  endtask

  task automatic report_mismatch(input string what);
    errors++;
    $display("[%0t] MISMATCH %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker and watchdog, sampled at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    bond_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.source_index, out_ch.neighbor_index, out_ch.layer,
              out_ch.found, out_ch.last};
      if (expected_bonds.size() == 0) begin
        report_mismatch($sformatf("unexpected item src=%0d nbr=%0d",
                                  got.src, got.nbr));
      end else begin
        want = expected_bonds.pop_front();
        if (got.found) n_bonds++;
        if (got != want)
          report_mismatch($sformatf(
            "got src=%0d nbr=%0d layer=%0b found=%0b last=%0b, want %0d/%0d/%0b/%0b/%0b",
            got.src, got.nbr, got.layer, got.found, got.last,
            want.src, want.nbr, want.layer, want.found, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver backpressure, changed at the falling edge
  int stall_cnt;
  always @(negedge clk) begin
    case (stall_mode)
      0: out_ch.ready = 1'b1;
      1: out_ch.ready = ($urandom_range(0, 99) < 70);
      default: begin
        // long stalls: held low a while, then open a while
        if (stall_cnt == 0) begin
          stall_cnt = $urandom_range(1, 20);
          out_ch.ready = !out_ch.ready;
        end else stall_cnt--;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  int burst_left;

  // drive one item at the falling edge, predict on its acceptance
  task automatic send_item(input stim_t s);
    if (bursty) begin
      if (burst_left == 0) begin
        repeat ($urandom_range(1, 6)) begin
          in_ch.valid = 1'b0;
          @(negedge clk);
        end
        burst_left = $urandom_range(1, 8);
      end
      burst_left--;
    end
    in_ch.valid       = 1'b1;
    in_ch.cmd         = s.cmd;
    in_ch.coord_x     = s.x;
    in_ch.coord_y     = s.y;
    in_ch.coord_z     = s.z;
    in_ch.query_index = s.qi;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_items++;
    if (s.typed) begin
      // no-bond answer read straight off the command; shadow state unchanged
      expect_item('{s.qi, '0, 1'b0, 1'b0, 1'b1});
      n_queries++;
    end else predict_bonds(s);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // quiet the block: all results in, then a margin for a scan in flight
  task automatic drain();
    while (expected_bonds.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [cnb_pkg::REG_W-1:0] idx,
                           input logic [cnb_pkg::CUT_W-1:0] val);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    n_cfg++;
    case (idx)
      cnb_pkg::REG_NEAR: near_cut   = val;
      cnb_pkg::REG_FAR:  far_cut    = val;
      cnb_pkg::REG_MAXN: bond_limit = val[cnb_pkg::MAXN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic stim_t mk(input logic [1:0] c, input int x, input int y,
                               input int z, input int q, input bit t = 1'b0);
    stim_t s;
    s.cmd = c;
    s.x = x[cnb_pkg::COORD_W-1:0];
    s.y = y[cnb_pkg::COORD_W-1:0];
    s.z = z[cnb_pkg::COORD_W-1:0];
    s.qi = q[cnb_pkg::IDX_W-1:0];
    s.typed = t;
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  stim_t directed[$];

  // append one row to the directed table
  function automatic void add_row(input stim_t s);
    directed = {directed, s};
  endfunction

  initial begin
    int cx, cy, cz, spread, r, near_v;
    stim_t s;

    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = cnb_pkg::CMD_CLEAR;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    in_ch.coord_z = '0;
    in_ch.query_index = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = cnb_pkg::REG_NEAR;
    cfg_ch.data = '0;
    out_ch.ready = 1'b1;
    stall_mode = 0;
    stall_cnt = 0;
    bursty = 1'b0;
    burst_left = 0;
    errors = 0;
    n_items = 0; n_queries = 0; n_bonds = 0; n_cfg = 0;
    idle_cycles = 0;
    pt_count = 0;
    near_cut = cnb_pkg::RST_NEAR;
    far_cut = cnb_pkg::RST_FAR;
    bond_limit = cnb_pkg::RST_MAXN;

    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // directed part: empty store, coordinate extremes, near and far shells,
    // a bond cut by a keep-out circle, out-of-range queries, unknown command
    add_row(mk(cnb_pkg::CMD_QUERY, 0, 0, 0, 0, 1'b1));
    add_row(mk(cnb_pkg::CMD_QUERY, 0, 0, 0, 1023, 1'b1));
    add_row(mk(CMD_NOP, -1, -1, -1, 1023));
    add_row(mk(cnb_pkg::CMD_LOAD, -8388608, -8388608, -8388608, 0));
    add_row(mk(cnb_pkg::CMD_LOAD, 8388607, 8388607, 8388607, 0));
    add_row(mk(cnb_pkg::CMD_QUERY, 0, 0, 0, 0));
    add_row(mk(cnb_pkg::CMD_QUERY, 0, 0, 0, 1));
    add_row(mk(cnb_pkg::CMD_QUERY, 0, 0, 0, 2, 1'b1));
    add_row(mk(cnb_pkg::CMD_CLEAR, 0, 0, 0, 0));
    add_row(mk(cnb_pkg::CMD_QUERY, 0, 0, 0, 0, 1'b1));
    for (int i = 0; i < 6; i++)
      add_row(mk(cnb_pkg::CMD_LOAD, -1000000 + i * 10000, 0, i * 3000, 0));
    add_row(mk(cnb_pkg::CMD_QUERY, 0, 0, 0, 0));
    add_row(mk(cnb_pkg::CMD_QUERY, 0, 0, 0, 3));
    // pair straddling the edge of the lower-left circle
    add_row(mk(cnb_pkg::CMD_LOAD, 320000, 665846, 0, 0));
    add_row(mk(cnb_pkg::CMD_LOAD, 350000, 665846, 0, 0));
    add_row(mk(cnb_pkg::CMD_LOAD, 360000, 680000, 0, 0));
    add_row(mk(cnb_pkg::CMD_QUERY, 0, 0, 0, 6));
    add_row(mk(cnb_pkg::CMD_QUERY, 0, 0, 0, 7));
    add_row(mk(cnb_pkg::CMD_QUERY, 0, 0, 0, 9, 1'b1));
    add_row(mk(cnb_pkg::CMD_QUERY, 0, 0, 0, 1000, 1'b1));
    foreach (directed[i]) send_item(directed[i]);
    drain();

    // random phases: new register setting, then clustered loads and queries
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      stall_mode = ph % 3;
      bursty = (ph % 4) != 1;
      if (ph == 0) begin
        write_reg(cnb_pkg::REG_NEAR, '0);         // every bond in the far shell
        write_reg(cnb_pkg::REG_FAR, 23'h7FFFFF);
        write_reg(cnb_pkg::REG_MAXN, 5'd31);      // saturates to the bond cap
      end else if (ph == 1) begin
        write_reg(cnb_pkg::REG_NEAR, 23'h7FFFFF);
        write_reg(cnb_pkg::REG_FAR, '0);          // nothing can bond
        write_reg(cnb_pkg::REG_MAXN, 5'd0);
      end else begin
        near_v = $urandom_range(3000, 40000);
        write_reg(cnb_pkg::REG_NEAR, cnb_pkg::CUT_W'(near_v));
        write_reg(cnb_pkg::REG_FAR, cnb_pkg::CUT_W'(near_v + $urandom_range(0, 40000)));
        write_reg(cnb_pkg::REG_MAXN,
                  cnb_pkg::MAXN_W'(ph == 2 ? 1 : $urandom_range(0, 20)));
      end
      send_item(mk(cnb_pkg::CMD_CLEAR, 0, 0, 0, 0));
      cx = $urandom_range(0, 3500000) - 1500000;
      cy = $urandom_range(0, 3000000) - 500000;
      cz = $urandom_range(0, 200000) - 100000;
      spread = $urandom_range(5000, 60000);
      for (int it = 0; it < PHASE_ITEMS; it++) begin
        r = $urandom_range(0, 99);
        if (r < 45 && pt_count < CLUSTER_CAP) begin
          s = mk(cnb_pkg::CMD_LOAD, cx + $urandom_range(0, 2 * spread) - spread,
                 cy + $urandom_range(0, 2 * spread) - spread,
                 cz + $urandom_range(0, 2 * spread) - spread, $urandom);
        end else if (r < 88 && pt_count > 0) begin
          s = mk(cnb_pkg::CMD_QUERY, $urandom, $urandom, $urandom,
                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                             : $urandom_range(0, pt_count - 1));
        end else if (r < 92) begin
          s = mk(cnb_pkg::CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
          cx = $urandom_range(0, 3500000) - 1500000;
          cy = $urandom_range(0, 3000000) - 500000;
        end else if (r < 96) begin
          s = mk(CMD_NOP, $urandom, $urandom, $urandom, $urandom);
        end else begin
          // stray load anywhere in the coordinate range
          s = mk(cnb_pkg::CMD_LOAD, $urandom, $urandom, $urandom, $urandom);
        end
        send_item(s);
      end
      drain();
    end

    $display("covered %0d items, %0d queries, %0d bonds, %0d register writes",
             n_items, n_queries, n_bonds, n_cfg);
    $display("settings swept: cutoff extremes, bond limits 0..31, stalls on both sides");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
